FILE: design/trz_pkg.sv
// Shared types, widths, command codes and the setup multiply program of the
// triangle rasterizer. No dependencies; every other design file but trz_ram imports it.
`default_nettype none

package trz_pkg;

  // Frame size defaults
  localparam int DEF_FRAME_WIDTH  = 512;
  localparam int DEF_FRAME_HEIGHT = 512;

  // Field widths
  localparam int MODE_W  = 2;
  localparam int COORD_W = 16;
  localparam int DEPTH_W = 24;
  localparam int COLOR_W = 24;
  localparam int IDX_W   = 18;
  localparam int COUNT_W = 19;

  // Internal arithmetic widths
  localparam int DIFF_W  = 17;   // coordinate differences
  localparam int BOX_W   = 15;   // signed bounding box bounds in pixels
  localparam int PC_W    = 19;   // pixel center offsets in Q15.4
  localparam int DZ_W    = 25;   // signed depth differences
  localparam int EDGE_W  = 40;   // edge values and doubled area
  localparam int GRAD_W  = 48;   // depth gradient numerators
  localparam int ACC_W   = 64;   // depth numerator
  localparam int DEN_W   = 36;   // doubled area magnitude
  localparam int DIVD_W  = 60;   // dividend of the depth division
  localparam int HALF_W  = 20;   // split point of wide multiplicands
  localparam int MA_W    = 21;   // multiplier operand A
  localparam int MB_W    = 26;   // multiplier operand B
  localparam int MP_W    = MA_W + MB_W;
  localparam int WORD_W  = COLOR_W + DEPTH_W;

  // Command codes
  localparam logic [MODE_W-1:0] MODE_DRAW  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  // Operand A selects
  localparam logic [3:0] A_E0X    = 4'd0;
  localparam logic [3:0] A_E0Y    = 4'd1;
  localparam logic [3:0] A_E1X    = 4'd2;
  localparam logic [3:0] A_E1Y    = 4'd3;
  localparam logic [3:0] A_DEN_LO = 4'd4;
  localparam logic [3:0] A_DEN_HI = 4'd5;
  localparam logic [3:0] A_N0_LO  = 4'd6;
  localparam logic [3:0] A_N0_HI  = 4'd7;
  localparam logic [3:0] A_N1_LO  = 4'd8;
  localparam logic [3:0] A_N1_HI  = 4'd9;

  // Operand B selects
  localparam logic [2:0] B_E1Y = 3'd0;
  localparam logic [2:0] B_DAY = 3'd1;
  localparam logic [2:0] B_DXS = 3'd2;
  localparam logic [2:0] B_DYS = 3'd3;
  localparam logic [2:0] B_DZA = 3'd4;
  localparam logic [2:0] B_DZB = 3'd5;
  localparam logic [2:0] B_CZ  = 3'd6;

  // Sum destinations
  localparam logic [2:0] D_NONE = 3'd0;
  localparam logic [2:0] D_DEN  = 3'd1;
  localparam logic [2:0] D_N0   = 3'd2;
  localparam logic [2:0] D_N1   = 3'd3;
  localparam logic [2:0] D_GX   = 3'd4;
  localparam logic [2:0] D_GY   = 3'd5;
  localparam logic [2:0] D_ACC  = 3'd6;

  localparam int MAC_STEPS = 16;

  typedef struct packed {
    logic [3:0] a_sel;
    logic [2:0] b_sel;
    logic       hi;     // shift product up by HALF_W
    logic       first;  // start a new sum
    logic       last;   // store the sum
    logic [2:0] dest;
  } mac_op_t;

  // Setup program: one product term per step
  function automatic mac_op_t mac_prog(input logic [3:0] step);
    mac_op_t op;
    op = '0;
    unique case (step)
      4'd0:  op = '{A_E0X,    B_E1Y, 1'b0, 1'b1, 1'b0, D_NONE};
      4'd1:  op = '{A_E0Y,    B_DAY, 1'b0, 1'b0, 1'b1, D_DEN};
      4'd2:  op = '{A_E0X,    B_DXS, 1'b0, 1'b1, 1'b0, D_NONE};
      4'd3:  op = '{A_E0Y,    B_DYS, 1'b0, 1'b0, 1'b1, D_N0};
      4'd4:  op = '{A_E1X,    B_DXS, 1'b0, 1'b1, 1'b0, D_NONE};
      4'd5:  op = '{A_E1Y,    B_DYS, 1'b0, 1'b0, 1'b1, D_N1};
      4'd6:  op = '{A_E0X,    B_DZA, 1'b0, 1'b1, 1'b0, D_NONE};
      4'd7:  op = '{A_E1X,    B_DZB, 1'b0, 1'b0, 1'b1, D_GX};
      4'd8:  op = '{A_E0Y,    B_DZA, 1'b0, 1'b1, 1'b0, D_NONE};
      4'd9:  op = '{A_E1Y,    B_DZB, 1'b0, 1'b0, 1'b1, D_GY};
      4'd10: op = '{A_DEN_LO, B_CZ,  1'b0, 1'b1, 1'b0, D_NONE};
      4'd11: op = '{A_DEN_HI, B_CZ,  1'b1, 1'b0, 1'b0, D_NONE};
      4'd12: op = '{A_N0_LO,  B_DZA, 1'b0, 1'b0, 1'b0, D_NONE};
      4'd13: op = '{A_N0_HI,  B_DZA, 1'b1, 1'b0, 1'b0, D_NONE};
      4'd14: op = '{A_N1_LO,  B_DZB, 1'b0, 1'b0, 1'b0, D_NONE};
      4'd15: op = '{A_N1_HI,  B_DZB, 1'b1, 1'b0, 1'b1, D_ACC};
    endcase
    return op;
  endfunction

endpackage

`default_nettype wire

FILE: design/trz_cmd_if.sv
// Command channel of the rasterizer: valid/ready plus one command word.
// Depends on trz_pkg for field widths.
`default_nettype none

interface trz_cmd_if;
  import trz_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [MODE_W-1:0]          mode;
  logic signed [COORD_W-1:0]  ax;
  logic signed [COORD_W-1:0]  ay;
  logic [DEPTH_W-1:0]         az;
  logic signed [COORD_W-1:0]  bx;
  logic signed [COORD_W-1:0]  by_coord;
  logic [DEPTH_W-1:0]         bz;
  logic signed [COORD_W-1:0]  cx;
  logic signed [COORD_W-1:0]  cy;
  logic [DEPTH_W-1:0]         cz;
  logic [COLOR_W-1:0]         fill_color;
  logic [IDX_W-1:0]           pixel_index;

  modport source (output valid, mode, ax, ay, az, bx, by_coord, bz, cx, cy, cz,
                  fill_color, pixel_index, input ready);
  modport sink (input valid, mode, ax, ay, az, bx, by_coord, bz, cx, cy, cz,
                fill_color, pixel_index, output ready);
endinterface

`default_nettype wire

FILE: design/trz_res_if.sv
// Result channel of the rasterizer: valid/ready plus one result word.
// Depends on trz_pkg for field widths.
`default_nettype none

interface trz_res_if;
  import trz_pkg::*;
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] read_color;
  logic [DEPTH_W-1:0] read_depth;
  logic [COUNT_W-1:0] pixels_written;
  logic               skipped;

  modport source (output valid, read_color, read_depth, pixels_written, skipped,
                  input ready);
  modport sink (input valid, read_color, read_depth, pixels_written, skipped,
                output ready);
endinterface

`default_nettype wire

FILE: design/trz_ram.sv
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module trz_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

FILE: design/trz_div.sv
// Restoring divider for the interpolated depth: one quotient bit per cycle.
// Depends on trz_pkg for widths.
`default_nettype none

module trz_div
  import trz_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [DEN_W-1:0]  divisor,
  output logic              done,
  output logic [DEPTH_W-1:0] quot
);

  localparam int CW = $clog2(DEPTH_W);

  logic [DIVD_W-1:0] rem;
  logic [DIVD_W-1:0] dsh;
  logic [CW-1:0]     cnt;
  logic              busy;
  logic              ge;

  assign ge = rem >= dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(DEPTH_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Quotient fits DEPTH_W bits, so start with the divisor aligned to its top bit
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend;
      dsh <= DIVD_W'(divisor) << (DEPTH_W - 1);
    end else if (busy) begin
      if (ge) rem <= rem - dsh;
      dsh  <= dsh >> 1;
      quot <= {quot[DEPTH_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

FILE: design/triangle_raster_zbuffer.sv
// Triangle rasterizer with depth buffer: top level, sequencer and datapath.
// Depends on trz_pkg, trz_cmd_if, trz_res_if, trz_ram and trz_div.
//
// One command word in, one result word out. Colour and depth of every pixel
// live side by side in one single-port RAM of FRAME_WIDTH*FRAME_HEIGHT words.
// After reset the block sweeps the RAM once, writing colour zero and farthest
// depth, one word per cycle, before it takes the first command; a clear
// command runs the same sweep with its colour. A draw first runs a setup, in
// which one shared 21x26 multiplier works through 16 product terms (doubled
// area, edge values at the first pixel center, depth gradients and the depth
// numerator), then walks the clipped bounding box in raster order: a pixel
// outside the triangle is skipped, a covered pixel goes through the bit-serial
// depth divider (24 steps) and the read-compare-write of the RAM.
// Edge values and the depth numerator advance by additions only. A new
// command is taken while the previous result still waits in the output
// register.
`default_nettype none

module triangle_raster_zbuffer
  import trz_pkg::*;
#(
  parameter int FRAME_WIDTH  = DEF_FRAME_WIDTH,
  parameter int FRAME_HEIGHT = DEF_FRAME_HEIGHT
) (
  input  wire logic  clk,
  input  wire logic  rst,
  trz_cmd_if.sink    cmd,
  trz_res_if.source  res
);

  localparam int PIX = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int AW  = $clog2(PIX);
  localparam int XW  = $clog2(FRAME_WIDTH);
  localparam int YW  = $clog2(FRAME_HEIGHT);

  localparam logic [3:0] ST_CLR  = 4'd0;
  localparam logic [3:0] ST_IDLE = 4'd1;
  localparam logic [3:0] ST_MAC  = 4'd2;
  localparam logic [3:0] ST_INIT = 4'd3;
  localparam logic [3:0] ST_SCAN = 4'd4;
  localparam logic [3:0] ST_DIV  = 4'd5;
  localparam logic [3:0] ST_CMP  = 4'd6;
  localparam logic [3:0] ST_RD0  = 4'd7;
  localparam logic [3:0] ST_RD1  = 4'd8;
  localparam logic [3:0] ST_DONE = 4'd9;

  function automatic logic signed [COORD_W-1:0] min3(
    input logic signed [COORD_W-1:0] a, b, c);
    logic signed [COORD_W-1:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic logic signed [COORD_W-1:0] max3(
    input logic signed [COORD_W-1:0] a, b, c);
    logic signed [COORD_W-1:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  logic [3:0] state;

  // Captured command word
  logic [MODE_W-1:0]         mode_q;
  logic signed [COORD_W-1:0] ax_q, ay_q, bx_q, by_q, cx_q, cy_q;
  logic [DEPTH_W-1:0]        az_q, bz_q, cz_q;
  logic [COLOR_W-1:0]        fill_q;
  logic [IDX_W-1:0]          pix_q;

  // Clear sweep
  logic [AW-1:0]      clr_addr;
  logic [COLOR_W-1:0] clr_color;
  logic               clr_reply;

  // Pending result and output register
  logic [COLOR_W-1:0] p_color;
  logic [DEPTH_W-1:0] p_depth;
  logic               p_skip;
  logic [COUNT_W-1:0] written;
  logic               res_valid;
  logic [COLOR_W-1:0] res_color;
  logic [DEPTH_W-1:0] res_depth;
  logic [COUNT_W-1:0] res_count;
  logic               res_skip;

  // Bounding box
  logic signed [COORD_W-1:0] minx, maxx, miny, maxy;
  logic signed [BOX_W-1:0]   bx0, bx1, by0, by1;
  logic                      offframe;
  logic [XW-1:0]             x0c, x1c;
  logic [YW-1:0]             y0c, y1c;
  logic signed [PC_W-1:0]    px0, py0;

  // Setup operands
  logic signed [DIFF_W-1:0] e0x, e0y, e1x, e1y, day;
  logic signed [PC_W-1:0]   dxs, dys;
  logic signed [DZ_W-1:0]   dza, dzb;

  // Setup multiply-accumulate
  logic [4:0]                step;
  mac_op_t                   op, op_d;
  logic                      op_v;
  logic signed [MA_W-1:0]    a_val;
  logic signed [MB_W-1:0]    b_val;
  logic signed [MP_W-1:0]    prod;
  logic signed [ACC_W-1:0]   term, mac_sum, mac_acc;
  logic signed [EDGE_W-1:0]  den_raw, n0_raw, n1_raw;
  logic signed [GRAD_W-1:0]  gx, gy;
  logic signed [ACC_W-1:0]   acc_raw;
  logic                      neg;

  // Scan state
  logic [DEN_W-1:0]          den;
  logic signed [EDGE_W-1:0]  n0, n1, n0_row, n1_row, n2;
  logic signed [EDGE_W-1:0]  dnx0, dny0, dnx1, dny1;
  logic signed [ACC_W-1:0]   acc, acc_row, dax, dayz;
  logic [XW-1:0]             x;
  logic [YW-1:0]             y;
  logic [AW-1:0]             row_base;
  logic                      covered;
  logic                      adv;

  // RAM and divider
  logic                ram_we;
  logic [AW-1:0]       ram_addr;
  logic [WORD_W-1:0]   ram_wdata, ram_rdata;
  logic [AW-1:0]       pix_addr;
  logic [31:0]         pix_wide, cmd_pix_wide;
  logic                div_start, div_done;
  logic [DEPTH_W-1:0]  div_quot;
  logic                nearer;

  // ---------------- bounding box, clipped to the frame ----------------
  assign minx = min3(ax_q, bx_q, cx_q);
  assign maxx = max3(ax_q, bx_q, cx_q);
  assign miny = min3(ay_q, by_q, cy_q);
  assign maxy = max3(ay_q, by_q, cy_q);

  // floor(v/16) is an arithmetic shift; ceil adds 15 first
  assign bx0 = BOX_W'($signed(minx[COORD_W-1:4]));
  assign by0 = BOX_W'($signed(miny[COORD_W-1:4]));
  assign bx1 = BOX_W'((DIFF_W'(maxx) + DIFF_W'(15)) >>> 4);
  assign by1 = BOX_W'((DIFF_W'(maxy) + DIFF_W'(15)) >>> 4);

  assign offframe = (bx1 < 0) || (by1 < 0) || (bx0 >= BOX_W'(FRAME_WIDTH)) ||
                    (by0 >= BOX_W'(FRAME_HEIGHT));

  assign x0c = (bx0 < 0) ? '0 : XW'(bx0);
  assign y0c = (by0 < 0) ? '0 : YW'(by0);
  assign x1c = (bx1 > BOX_W'(FRAME_WIDTH - 1))  ? XW'(FRAME_WIDTH - 1)  : XW'(bx1);
  assign y1c = (by1 > BOX_W'(FRAME_HEIGHT - 1)) ? YW'(FRAME_HEIGHT - 1) : YW'(by1);

  // First pixel center in Q15.4
  assign px0 = $signed(PC_W'({x0c, 4'b1000}));
  assign py0 = $signed(PC_W'({y0c, 4'b1000}));

  assign e0x = DIFF_W'(by_q) - DIFF_W'(cy_q);
  assign e0y = DIFF_W'(cx_q) - DIFF_W'(bx_q);
  assign e1x = DIFF_W'(cy_q) - DIFF_W'(ay_q);
  assign e1y = DIFF_W'(ax_q) - DIFF_W'(cx_q);
  assign day = DIFF_W'(ay_q) - DIFF_W'(cy_q);
  assign dxs = px0 - PC_W'(cx_q);
  assign dys = py0 - PC_W'(cy_q);
  assign dza = $signed(DZ_W'(az_q)) - $signed(DZ_W'(cz_q));
  assign dzb = $signed(DZ_W'(bz_q)) - $signed(DZ_W'(cz_q));

  // ---------------- setup multiplier ----------------
  assign op = mac_prog(step[3:0]);

  always_comb begin
    case (op.a_sel)
      A_E0X:    a_val = MA_W'(e0x);
      A_E0Y:    a_val = MA_W'(e0y);
      A_E1X:    a_val = MA_W'(e1x);
      A_E1Y:    a_val = MA_W'(e1y);
      A_DEN_LO: a_val = $signed({1'b0, den_raw[HALF_W-1:0]});
      A_DEN_HI: a_val = MA_W'($signed(den_raw[EDGE_W-1:HALF_W]));
      A_N0_LO:  a_val = $signed({1'b0, n0_raw[HALF_W-1:0]});
      A_N0_HI:  a_val = MA_W'($signed(n0_raw[EDGE_W-1:HALF_W]));
      A_N1_LO:  a_val = $signed({1'b0, n1_raw[HALF_W-1:0]});
      A_N1_HI:  a_val = MA_W'($signed(n1_raw[EDGE_W-1:HALF_W]));
      default:  a_val = '0;
    endcase
    case (op.b_sel)
      B_E1Y:   b_val = MB_W'(e1y);
      B_DAY:   b_val = MB_W'(day);
      B_DXS:   b_val = MB_W'(dxs);
      B_DYS:   b_val = MB_W'(dys);
      B_DZA:   b_val = MB_W'(dza);
      B_DZB:   b_val = MB_W'(dzb);
      B_CZ:    b_val = $signed(MB_W'(cz_q));
      default: b_val = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= a_val * b_val;
    op_d <= op;
  end

  assign term    = op_d.hi ? (ACC_W'(prod) <<< HALF_W) : ACC_W'(prod);
  assign mac_sum = op_d.first ? term : mac_acc + term;
  assign neg     = den_raw[EDGE_W-1];

  // ---------------- scan datapath ----------------
  assign n2      = $signed(EDGE_W'(den)) - n0 - n1;
  assign covered = !n0[EDGE_W-1] && !n1[EDGE_W-1] && !n2[EDGE_W-1];
  assign adv     = ((state == ST_SCAN) && !covered) || (state == ST_CMP);

  assign pix_addr     = AW'(row_base + AW'(x));
  assign pix_wide     = 32'(pix_q);
  assign cmd_pix_wide = 32'(cmd.pixel_index);
  assign nearer       = div_quot < ram_rdata[DEPTH_W-1:0];
  assign div_start    = (state == ST_SCAN) && covered;

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = pix_addr;
    ram_wdata = {clr_color, {DEPTH_W{1'b1}}};
    case (state)
      ST_CLR: begin
        ram_we   = 1'b1;
        ram_addr = clr_addr;
      end
      ST_RD0: ram_addr = pix_wide[AW-1:0];
      ST_CMP: begin
        ram_we    = nearer;
        ram_wdata = {fill_q, div_quot};
      end
      default: ;
    endcase
  end

  trz_ram #(
    .WIDTH (WORD_W),
    .DEPTH (PIX)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Numerator is non-negative and below den * 2^24 on a covered pixel
  trz_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (acc[DIVD_W-1:0]),
    .divisor  (den),
    .done     (div_done),
    .quot     (div_quot)
  );

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLR;
      clr_addr  <= '0;
      clr_color <= '0;
      clr_reply <= 1'b0;
      step      <= '0;
      op_v      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      op_v <= (state == ST_MAC) && (step < 5'(MAC_STEPS));
      // Drop the word once taken, unless a new one is loaded this cycle
      if (res_valid && res.ready && (state != ST_DONE)) res_valid <= 1'b0;

      unique case (state)
        ST_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(PIX - 1)) begin
            state     <= clr_reply ? ST_DONE : ST_IDLE;
            clr_reply <= 1'b0;
          end
        end

        ST_IDLE: begin
          if (cmd.valid) begin
            mode_q  <= cmd.mode;
            ax_q    <= cmd.ax;
            ay_q    <= cmd.ay;
            az_q    <= cmd.az;
            bx_q    <= cmd.bx;
            by_q    <= cmd.by_coord;
            bz_q    <= cmd.bz;
            cx_q    <= cmd.cx;
            cy_q    <= cmd.cy;
            cz_q    <= cmd.cz;
            fill_q  <= cmd.fill_color;
            pix_q   <= cmd.pixel_index;
            p_color <= '0;
            p_depth <= '0;
            p_skip  <= 1'b0;
            written <= '0;
            unique case (cmd.mode)
              MODE_DRAW: begin
                step  <= '0;
                state <= ST_MAC;
              end
              MODE_READ: state <= (cmd_pix_wide < 32'(PIX)) ? ST_RD0 : ST_DONE;
              MODE_CLEAR: begin
                clr_addr  <= '0;
                clr_color <= cmd.fill_color;
                clr_reply <= 1'b1;
                state     <= ST_CLR;
              end
              default: state <= ST_DONE;
            endcase
          end
        end

        ST_MAC: begin
          step <= step + 1'b1;
          if (op_v) begin
            mac_acc <= mac_sum;
            if (op_d.last) begin
              case (op_d.dest)
                D_DEN:   den_raw <= mac_sum[EDGE_W-1:0];
                D_N0:    n0_raw  <= mac_sum[EDGE_W-1:0];
                D_N1:    n1_raw  <= mac_sum[EDGE_W-1:0];
                D_GX:    gx      <= mac_sum[GRAD_W-1:0];
                D_GY:    gy      <= mac_sum[GRAD_W-1:0];
                D_ACC:   acc_raw <= mac_sum;
                default: ;
              endcase
            end
          end
          if (step == 5'(MAC_STEPS)) begin
            // Off-frame box first, then zero area
            if (offframe || (den_raw == '0)) begin
              p_skip <= 1'b1;
              state  <= ST_DONE;
            end else begin
              state <= ST_INIT;
            end
          end
        end

        ST_INIT: begin
          // Fold the sign of the area into every edge term
          den     <= neg ? DEN_W'(-den_raw) : DEN_W'(den_raw);
          n0      <= neg ? -n0_raw : n0_raw;
          n0_row  <= neg ? -n0_raw : n0_raw;
          n1      <= neg ? -n1_raw : n1_raw;
          n1_row  <= neg ? -n1_raw : n1_raw;
          acc     <= neg ? -acc_raw : acc_raw;
          acc_row <= neg ? -acc_raw : acc_raw;
          dnx0    <= neg ? -(EDGE_W'(e0x) <<< 4) : (EDGE_W'(e0x) <<< 4);
          dny0    <= neg ? -(EDGE_W'(e0y) <<< 4) : (EDGE_W'(e0y) <<< 4);
          dnx1    <= neg ? -(EDGE_W'(e1x) <<< 4) : (EDGE_W'(e1x) <<< 4);
          dny1    <= neg ? -(EDGE_W'(e1y) <<< 4) : (EDGE_W'(e1y) <<< 4);
          dax     <= neg ? -(ACC_W'(gx) <<< 4) : (ACC_W'(gx) <<< 4);
          dayz    <= neg ? -(ACC_W'(gy) <<< 4) : (ACC_W'(gy) <<< 4);
          x        <= x0c;
          y        <= y0c;
          row_base <= AW'(y0c * FRAME_WIDTH);
          state    <= ST_SCAN;
        end

        ST_SCAN: begin
          if (covered) state <= ST_DIV;
        end

        ST_DIV: begin
          if (div_done) state <= ST_CMP;
        end

        ST_CMP: begin
          if (nearer) written <= written + 1'b1;
        end

        ST_RD0: state <= ST_RD1;

        ST_RD1: begin
          p_color <= ram_rdata[WORD_W-1:DEPTH_W];
          p_depth <= ram_rdata[DEPTH_W-1:0];
          state   <= ST_DONE;
        end

        ST_DONE: begin
          if (!res_valid || res.ready) begin
            res_color <= p_color;
            res_depth <= p_depth;
            res_count <= written;
            res_skip  <= p_skip;
            res_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase

      // Advance to the next pixel of the box in raster order
      if (adv) begin
        if (x == x1c) begin
          if (y == y1c) begin
            state <= ST_DONE;
          end else begin
            y        <= y + 1'b1;
            x        <= x0c;
            row_base <= row_base + AW'(FRAME_WIDTH);
            n0_row   <= n0_row + dny0;
            n0       <= n0_row + dny0;
            n1_row   <= n1_row + dny1;
            n1       <= n1_row + dny1;
            acc_row  <= acc_row + dayz;
            acc      <= acc_row + dayz;
            state    <= ST_SCAN;
          end
        end else begin
          x     <= x + 1'b1;
          n0    <= n0 + dnx0;
          n1    <= n1 + dnx1;
          acc   <= acc + dax;
          state <= ST_SCAN;
        end
      end
    end
  end

  assign cmd.ready          = (state == ST_IDLE);
  assign res.valid          = res_valid;
  assign res.read_color     = res_color;
  assign res.read_depth     = res_depth;
  assign res.pixels_written = res_count;
  assign res.skipped        = res_skip;

`ifndef NO_ASSERTIONS
  // No store traffic while waiting for a command
  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !ram_we)
    else $error("store written while idle");

  // A depth write only ever brings a pixel nearer
  a_depth_nearer: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_CMP) && ram_we) |-> (ram_wdata[DEPTH_W-1:0] < ram_rdata[DEPTH_W-1:0]))
    else $error("depth write not nearer than stored depth");

  // Depth numerator of a covered pixel is never negative
  a_cov_acc_pos: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_SCAN) && covered) |-> !acc[ACC_W-1])
    else $error("negative depth numerator on covered pixel");

  // Divider completes only for a pixel under test
  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV))
    else $error("divider finished outside division wait");
`endif

endmodule

`default_nettype wire
